@@ sv/csp_pkg.sv @@
// Shared types and constants for the countdown and stopwatch pool.
// Holds request codes, the transaction structs and the packet passed along the cell chain.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SLOT_W  = 8;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_T_START = 3'd1,
    REQ_T_STOP  = 3'd2,
    REQ_T_READ  = 3'd3,
    REQ_W_START = 3'd4,
    REQ_W_STOP  = 3'd5,
    REQ_W_READ  = 3'd6
  } csp_req_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_NO_SLOT = 1'b1
  } csp_status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VALUE_W-1:0] amount_ms;
    logic [3:0]         slot_index;
  } csp_in_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         slot_out;
    logic [VALUE_W-1:0] value_ms;
    logic               active_flag;
  } csp_out_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [VALUE_W-1:0] amount_ms;
    logic [3:0]         slot_index;
    logic               claimed;
    logic [SLOT_W-1:0]  claim_slot;
    logic [VALUE_W-1:0] value_ms;
    logic               active;
  } csp_pkt_t;

endpackage

`default_nettype wire

@@ sv/csp_cell.sv @@
// One slot of the pool: a timer and a stopwatch entry plus the packet register.
// Applies the passing request to its own slot and hands the packet on; uses csp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csp_cell import csp_pkg::*; #(
  parameter int unsigned IDX       = 0,
  parameter bit          HAS_TIMER = 1'b1,
  parameter bit          HAS_WATCH = 1'b1
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     pkt_valid_i,
  input  wire csp_pkt_t pkt_i,
  output logic          pkt_valid_o,
  output csp_pkt_t      pkt_o
);

  logic [VALUE_W-1:0] tim_q, tim_d;
  logic               trun_q, trun_d;
  logic [VALUE_W-1:0] wat_q, wat_d;
  logic               wrun_q, wrun_d;
  logic               valid_q;
  csp_pkt_t           pkt_q, pkt_d;

  logic               hit;
  logic [VALUE_W:0]   wsum;

  assign hit  = ({{(SLOT_W-4){1'b0}}, pkt_i.slot_index} == SLOT_W'(IDX));
  assign wsum = {1'b0, wat_q} + {1'b0, pkt_i.amount_ms};

  always_comb begin
    tim_d  = tim_q;
    trun_d = trun_q;
    wat_d  = wat_q;
    wrun_d = wrun_q;
    pkt_d  = pkt_i;
    if (pkt_valid_i) begin
      case (pkt_i.req_type)
        REQ_TICK: begin
          if (HAS_TIMER && trun_q) begin
            if (tim_q <= pkt_i.amount_ms) begin
              tim_d  = '0;
              trun_d = 1'b0;
            end else begin
              tim_d = tim_q - pkt_i.amount_ms;
            end
          end
          if (HAS_WATCH && wrun_q) begin
            wat_d = wsum[VALUE_W] ? {VALUE_W{1'b1}} : wsum[VALUE_W-1:0];
          end
        end
        REQ_T_START: begin
          if (HAS_TIMER && !pkt_i.claimed && !trun_q) begin
            tim_d            = pkt_i.amount_ms;
            trun_d           = 1'b1;
            pkt_d.claimed    = 1'b1;
            pkt_d.claim_slot = SLOT_W'(IDX);
          end
        end
        REQ_T_STOP: begin
          if (HAS_TIMER && hit) begin
            tim_d  = '0;
            trun_d = 1'b0;
          end
        end
        REQ_T_READ: begin
          if (HAS_TIMER && hit) begin
            pkt_d.value_ms = tim_q;
            pkt_d.active   = trun_q;
          end
        end
        REQ_W_START: begin
          if (HAS_WATCH && !pkt_i.claimed && !wrun_q) begin
            wat_d            = '0;
            wrun_d           = 1'b1;
            pkt_d.claimed    = 1'b1;
            pkt_d.claim_slot = SLOT_W'(IDX);
          end
        end
        REQ_W_STOP: begin
          if (HAS_WATCH && hit) begin
            wat_d  = '0;
            wrun_d = 1'b0;
          end
        end
        REQ_W_READ: begin
          if (HAS_WATCH && hit) begin
            pkt_d.value_ms = wat_q;
            pkt_d.active   = wrun_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tim_q   <= '0;
      trun_q  <= 1'b0;
      wat_q   <= '0;
      wrun_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tim_q   <= tim_d;
      trun_q  <= trun_d;
      wat_q   <= wat_d;
      wrun_q  <= wrun_d;
      valid_q <= pkt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  assign pkt_valid_o = valid_q;
  assign pkt_o       = pkt_q;

endmodule

`default_nettype wire

@@ sv/countdown_and_stopwatch_pool_top.sv @@
// An accepted transaction walks the slot chain of max(NUM_TIMERS, NUM_WATCHES) cells, each
// holding it in its packet register; its result is then held in the output register.
// One request is in the chain at a time; the next is accepted only after its result is taken.
// Reset: asynchronous, active low; clears every slot to zero and idle and empties the chain.
// Depends on csp_pkg and csp_cell.
`timescale 1ns / 1ps
`default_nettype none

module countdown_and_stopwatch_pool_top import csp_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned NUM_WATCHES = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire csp_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output csp_out_t     out_data_o
);

  localparam int unsigned NCELL = (NUM_TIMERS > NUM_WATCHES) ? NUM_TIMERS : NUM_WATCHES;

  logic [NCELL:0] valid_w;
  csp_pkt_t       pkt_w [NCELL+1];

  logic           busy_q, busy_d;
  logic           out_valid_q, out_valid_d;
  csp_out_t       out_q, out_d;
  logic           in_fire, out_fire;
  logic           is_start;
  csp_pkt_t       last;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  assign valid_w[0] = in_fire;
  assign pkt_w[0]   = '{req_type:   in_data_i.req_type,
                        amount_ms:  in_data_i.amount_ms,
                        slot_index: in_data_i.slot_index,
                        claimed:    1'b0,
                        claim_slot: '0,
                        value_ms:   '0,
                        active:     1'b0};

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    csp_cell #(
      .IDX       (i),
      .HAS_TIMER (i < NUM_TIMERS),
      .HAS_WATCH (i < NUM_WATCHES)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .pkt_valid_i (valid_w[i]),
      .pkt_i       (pkt_w[i]),
      .pkt_valid_o (valid_w[i+1]),
      .pkt_o       (pkt_w[i+1])
    );
  end

  assign last     = pkt_w[NCELL];
  assign is_start = (last.req_type == REQ_T_START) || (last.req_type == REQ_W_START);

  always_comb begin
    out_d             = out_q;
    out_d.status      = STATUS_OK;
    out_d.slot_out    = '0;
    out_d.value_ms    = last.value_ms;
    out_d.active_flag = last.active;
    case (last.req_type)
      REQ_T_START, REQ_W_START: begin
        if (last.claimed) begin
          out_d.slot_out = last.claim_slot[3:0];
        end else begin
          out_d.status = STATUS_NO_SLOT;
        end
      end
      REQ_T_STOP, REQ_T_READ, REQ_W_STOP, REQ_W_READ: begin
        out_d.slot_out = last.slot_index;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (out_fire) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b0;
    end
    if (valid_w[NCELL]) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_w[NCELL]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({valid_w[NCELL:1], out_valid_q}))
    else $error("more than one transaction in the cell chain");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q && (valid_w[NCELL:1] == '0))
    else $error("input ready while a transaction is still in flight");

  a_result_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_w[NCELL]))
    else $error("result valid without a packet leaving the chain");

  a_ready_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> in_ready_o)
    else $error("input not ready after the result was taken");

  a_status_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[NCELL] && !is_start |=> out_data_o.status == STATUS_OK)
    else $error("no-slot status on a request that is not a start");
`endif

endmodule

`default_nettype wire

@@ tb/tb_countdown_and_stopwatch_pool_top.sv @@
// Self-checking testbench for countdown_and_stopwatch_pool_top: directed table, then random
// requests, each checked against its table entry or a behavioral model of the timer and stopwatch pool.
// Depends on csp_pkg and the RTL of the pool; drives both valid/ready channels with random stalls.
`timescale 1ns / 1ps

module tb_countdown_and_stopwatch_pool_top;
  import csp_pkg::*;

  localparam int          NUM_SLOTS    = 16;
  localparam int unsigned PHASE_ITEMS  = 400;
  localparam logic [2:0]  REQ_UNUSED   = 3'd7;

  typedef struct {
    csp_in_t     item;
    int unsigned reps;
    bit          typed;
    csp_out_t    want;
  } step_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  csp_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  csp_out_t out_data_o;

  logic [31:0] tmr_left [NUM_SLOTS];
  logic        tmr_run  [NUM_SLOTS];
  logic [31:0] sw_time  [NUM_SLOTS];
  logic        sw_run   [NUM_SLOTS];

  csp_out_t    pending_results [$];
  csp_out_t    oldest;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 27;
  int unsigned recv_idle_pct  = 86;

  countdown_and_stopwatch_pool_top #(
    .NUM_TIMERS (NUM_SLOTS),
    .NUM_WATCHES(NUM_SLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic csp_out_t pool_apply(input csp_in_t item);
    csp_out_t    res;
    logic [32:0] sum;
    int          pick;
    int          i;
    res  = '0;
    pick = -1;
    case (item.req_type)
      REQ_TICK: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (tmr_run[i]) begin
            if (tmr_left[i] <= item.amount_ms) begin
              tmr_left[i] = '0;
              tmr_run[i]  = 1'b0;
            end else begin
              tmr_left[i] = tmr_left[i] - item.amount_ms;
            end
          end
          if (sw_run[i]) begin
            sum        = {1'b0, sw_time[i]} + {1'b0, item.amount_ms};
            sw_time[i] = sum[32] ? '1 : sum[31:0];
          end
        end
      end
      REQ_T_START: begin
        for (i = NUM_SLOTS - 1; i >= 0; i--) if (!tmr_run[i]) pick = i;
        if (pick < 0) begin
          res.status = STATUS_NO_SLOT;
        end else begin
          tmr_run[pick]  = 1'b1;
          tmr_left[pick] = item.amount_ms;
          res.slot_out   = pick[3:0];
        end
      end
      REQ_W_START: begin
        for (i = NUM_SLOTS - 1; i >= 0; i--) if (!sw_run[i]) pick = i;
        if (pick < 0) begin
          res.status = STATUS_NO_SLOT;
        end else begin
          sw_run[pick]  = 1'b1;
          sw_time[pick] = '0;
          res.slot_out  = pick[3:0];
        end
      end
      REQ_T_STOP: begin
        tmr_run[item.slot_index]  = 1'b0;
        tmr_left[item.slot_index] = '0;
        res.slot_out              = item.slot_index;
      end
      REQ_W_STOP: begin
        sw_run[item.slot_index]  = 1'b0;
        sw_time[item.slot_index] = '0;
        res.slot_out             = item.slot_index;
      end
      REQ_T_READ: begin
        res.slot_out    = item.slot_index;
        res.value_ms    = tmr_left[item.slot_index];
        res.active_flag = tmr_run[item.slot_index];
      end
      REQ_W_READ: begin
        res.slot_out    = item.slot_index;
        res.value_ms    = sw_time[item.slot_index];
        res.active_flag = sw_run[item.slot_index];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic step_row_t row(input logic [2:0] op, input logic [31:0] amt,
                                    input logic [3:0] slot, input int unsigned reps,
                                    input bit typed, input logic status,
                                    input logic [3:0] slot_out);
    step_row_t r;
    r.item  = '{op, amt, slot};
    r.reps  = reps;
    r.typed = typed;
    r.want  = '{status, slot_out, 32'd0, 1'b0};
    return r;
  endfunction

  function automatic csp_in_t random_request();
    csp_in_t     item;
    int unsigned pick;
    item.amount_ms  = $urandom;
    item.slot_index = 4'($urandom_range(15));
    pick            = $urandom_range(99);
    if (pick < 25) begin
      item.req_type = REQ_TICK;
      case ($urandom_range(19))
        0:       item.amount_ms = '1;
        1:       item.amount_ms = $urandom;
        2:       item.amount_ms = '0;
        default: item.amount_ms = $urandom_range(300);
      endcase
    end else if (pick < 40) begin
      item.req_type = REQ_T_START;
      case ($urandom_range(9))
        0:       item.amount_ms = '0;
        1:       item.amount_ms = '1;
        2:       item.amount_ms = $urandom;
        default: item.amount_ms = $urandom_range(3000);
      endcase
    end else if (pick < 47) begin
      item.req_type = REQ_T_STOP;
    end else if (pick < 60) begin
      item.req_type = REQ_T_READ;
    end else if (pick < 72) begin
      item.req_type = REQ_W_START;
    end else if (pick < 79) begin
      item.req_type = REQ_W_STOP;
    end else if (pick < 97) begin
      item.req_type = REQ_W_READ;
    end else begin
      item.req_type = REQ_UNUSED;
    end
    return item;
  endfunction

  // Hold valid and payload until accepted; drop valid only across idle cycles.
  task automatic send_item(input csp_in_t item, input bit typed, input csp_out_t want);
    csp_out_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = pool_apply(item);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data_o);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        compare_field("status", 32'(oldest.status), 32'(out_data_o.status));
        compare_field("slot_out", 32'(oldest.slot_out), 32'(out_data_o.slot_out));
        compare_field("value_ms", oldest.value_ms, out_data_o.value_ms);
        compare_field("active_flag", 32'(oldest.active_flag), 32'(out_data_o.active_flag));
      end
    end
  end

  initial begin : stimulus
    step_row_t   plan [$];
    csp_in_t     item;
    logic [2:0]  burst_op;
    int unsigned phase;
    int unsigned sent;
    int unsigned k;
    for (k = 0; k < NUM_SLOTS; k++) begin
      tmr_left[k] = '0;
      tmr_run[k]  = 1'b0;
      sw_time[k]  = '0;
      sw_run[k]   = 1'b0;
    end
    plan.push_back(row(REQ_T_READ,  32'd0, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_W_READ,  32'd0, 4'd15, 1,  1'b1, STATUS_OK,      4'd15));
    plan.push_back(row(REQ_UNUSED,  '1,    4'd15, 1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_T_START, 32'd0, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_TICK,    32'd0, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_T_READ,  32'd0, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_T_START, '1,    4'd5,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_TICK,    32'd1, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_T_READ,  32'd0, 4'd0,  1,  1'b0, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_W_START, '1,    4'd0,  16, 1'b0, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_W_START, 32'd0, 4'd0,  1,  1'b1, STATUS_NO_SLOT, 4'd0));
    plan.push_back(row(REQ_TICK,    '1,    4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_TICK,    32'd5, 4'd0,  1,  1'b1, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_W_READ,  32'd0, 4'd15, 1,  1'b0, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_W_STOP,  32'd0, 4'd7,  1,  1'b1, STATUS_OK,      4'd7));
    plan.push_back(row(REQ_W_START, 32'd0, 4'd0,  1,  1'b1, STATUS_OK,      4'd7));
    plan.push_back(row(REQ_T_READ,  32'd0, 4'd0,  1,  1'b0, STATUS_OK,      4'd0));
    plan.push_back(row(REQ_T_STOP,  32'd0, 4'd15, 1,  1'b1, STATUS_OK,      4'd15));
    plan.push_back(row(REQ_T_READ,  32'd0, 4'd15, 1,  1'b1, STATUS_OK,      4'd15));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (k = 0; k < plan[r].reps; k++) send_item(plan[r].item, plan[r].typed, plan[r].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 27 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 3) begin
          // Send one more start than the pool has slots, so that at least one finds no free slot.
          burst_op = $urandom_range(1) ? REQ_T_START : REQ_W_START;
          for (k = 0; k <= NUM_SLOTS; k++) begin
            item = random_request();
            item.req_type  = burst_op;
            item.amount_ms = $urandom_range(5000);
            send_item(item, 1'b0, '0);
          end
          sent += NUM_SLOTS + 1;
        end else begin
          item = random_request();
          send_item(item, 1'b0, '0);
          if (item.req_type != REQ_UNUSED) sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/csp_pkg.sv
sv/csp_cell.sv
sv/countdown_and_stopwatch_pool_top.sv
tb/tb_countdown_and_stopwatch_pool_top.sv
